// ===== rtl/cap_pkg.sv =====
// ---------------------------------------------------------------------------
// cap_pkg
// Widths, register indexes, routing codes and reset values shared by the
// controlled audio amplifier.
// ---------------------------------------------------------------------------
package cap_pkg;

    // sample and gain formats
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = 18;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 18;
    localparam int AROUTE_BITS   = 2;
    localparam int CROUTE_BITS   = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUDIO_GAIN_ONE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUDIO_GAIN_TWO   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTROL_GAIN_ONE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTROL_GAIN_TWO = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTROL_STRENGTH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_LEVEL       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUDIO_ROUTING    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTROL_ROUTING  = 3'd7;

    // audio routing codes
    localparam logic [AROUTE_BITS-1:0] AROUTE_NONE = 2'd0;
    localparam logic [AROUTE_BITS-1:0] AROUTE_TWO  = 2'd1;
    localparam logic [AROUTE_BITS-1:0] AROUTE_ONE  = 2'd2;
    localparam logic [AROUTE_BITS-1:0] AROUTE_SUM  = 2'd3;

    // control routing codes
    localparam logic [CROUTE_BITS-1:0] CROUTE_NONE = 3'd0;
    localparam logic [CROUTE_BITS-1:0] CROUTE_TWO  = 3'd1;
    localparam logic [CROUTE_BITS-1:0] CROUTE_ONE  = 3'd2;
    localparam logic [CROUTE_BITS-1:0] CROUTE_SUM  = 3'd3;
    localparam logic [CROUTE_BITS-1:0] CROUTE_MUL  = 3'd4;

    // reset values
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY       = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_HALF        = GAIN_BITS'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [AROUTE_BITS-1:0] AROUTE_RESET   = AROUTE_SUM;
    localparam logic [CROUTE_BITS-1:0] CROUTE_RESET   = CROUTE_NONE;

    // datapath widths
    // gain times sample, gain taken as a non-negative signed value
    localparam int PROD_W   = GAIN_BITS + 1 + SAMPLE_BITS;
    // control term after dropping the sample fraction
    localparam int CTL_W    = PROD_W - (SAMPLE_BITS - 1);
    localparam int CSUM_W   = CTL_W + 1;
    localparam int CMUL_W   = 2 * GAIN_BITS;
    localparam int CMUL_SH  = CMUL_W - GAIN_FRAC_BITS;
    localparam int V_W      = (CMUL_SH > GAIN_BITS + 1) ? CMUL_SH : GAIN_BITS + 1;
    localparam int VS_W     = V_W + GAIN_BITS;
    localparam int LVL_W    = VS_W + 1;
    // audio path
    localparam int AU_SUM_W = PROD_W + 1;
    localparam int AU_W     = AU_SUM_W - GAIN_FRAC_BITS;
    localparam int Y_W      = AU_W + GAIN_BITS + 1;

    localparam int STAGES   = 6;

endpackage

// ===== rtl/controlled_audio_amplifier.sv =====
// ---------------------------------------------------------------------------
// controlled_audio_amplifier
// Voltage-controlled amplifier: two audio and two control samples per frame,
// control gain from routing, strength and base level, saturated output.
// ---------------------------------------------------------------------------
// Usage
// - input channel: i_in_valid / o_in_ready carry one frame per request
//   (two audio samples, two control samples, block end marker)
// - output channel: o_out_valid / i_out_ready carry one amplified sample
//   and the copied block end marker per frame, in arrival order
// - config port: i_cfg_we writes i_cfg_data to register i_cfg_idx at once;
//   write only while no frame is in flight
// - throughput: one frame per cycle when not stalled, through six register
//   stages: input products, control terms and control product, strength
//   product, base level and clamp, output product, rescale and saturation
// - stall: each stage holds while the one after it is full and stalled;
//   empty stages still fill, so o_in_ready drops only when all six are full
//   and i_out_ready is low
// - reset: synchronous, active low; empties the pipeline and loads the
//   register defaults (gains 1.0, strength 0.5, both audio inputs summed,
//   no control routing)
// ---------------------------------------------------------------------------
module controlled_audio_amplifier (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // config port
    input  logic                                       i_cfg_we,
    input  logic [cap_pkg::CFG_IDX_BITS-1:0]           i_cfg_idx,
    input  logic [cap_pkg::CFG_DATA_BITS-1:0]          i_cfg_data,
    // input channel
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0]     i_audio_one,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0]     i_audio_two,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0]     i_control_one,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0]     i_control_two,
    input  logic                                       i_block_end,
    // output channel
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [cap_pkg::SAMPLE_BITS-1:0]     o_amp_sample,
    output logic                                       o_block_end_out
);
    import cap_pkg::*;

    // configuration registers
    logic [GAIN_BITS-1:0]   r_again1, r_again2, r_cgain1, r_cgain2;
    logic [GAIN_BITS-1:0]   r_strength, r_base;
    logic [AROUTE_BITS-1:0] r_aroute;
    logic [CROUTE_BITS-1:0] r_croute;

    // pipeline control
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stg_en;
    logic [STAGES:0]   vld_in;

    // stage 1: input products
    logic signed [PROD_W-1:0] r_s1_pc1, r_s1_pc2, r_s1_pa1, r_s1_pa2;
    logic signed [PROD_W-1:0] n_s1_pc1, n_s1_pc2, n_s1_pa1, n_s1_pa2;
    logic                     r_s1_end;

    // stage 2: control selection and product, audio sum
    logic signed [CTL_W-1:0]    c1, c2;
    logic signed [CSUM_W-1:0]   term1, term2;
    logic                       use_c1, use_c2, use_mul, c1_pos, c2_pos;
    logic signed [AU_SUM_W-1:0] au_sum, au_sh;
    logic signed [CSUM_W-1:0]   r_s2_vsum, n_s2_vsum;
    logic [CMUL_W-1:0]          r_s2_cmul, n_s2_cmul;
    logic                       r_s2_mul;
    logic signed [AU_W-1:0]     r_s2_au;
    logic                       r_s2_end;

    // stage 3: strength product
    logic [V_W-1:0]         v_sel;
    logic [VS_W-1:0]        r_s3_vs, n_s3_vs;
    logic signed [AU_W-1:0] r_s3_au;
    logic                   r_s3_end;

    // stage 4: base level and clamp
    logic [LVL_W-1:0]       lvl;
    logic                   ctl_none;
    logic [GAIN_BITS-1:0]   r_s4_gain, n_s4_gain;
    logic signed [AU_W-1:0] r_s4_au;
    logic                   r_s4_end;

    // stage 5: output product
    logic signed [Y_W-1:0] r_s5_y, n_s5_y;
    logic                  r_s5_end;

    // stage 6: saturation, output register
    localparam logic signed [Y_W-1:0] SAT_MAX =
        {{(Y_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Y_W-1:0] SAT_MIN =
        {{(Y_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [LVL_W-1:0] LVL_UNITY = LVL_W'(1) << GAIN_FRAC_BITS;

    logic signed [Y_W-1:0]         y_sh;
    logic signed [SAMPLE_BITS-1:0] r_s6_out, n_s6_out;
    logic                          r_s6_end;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_again1   <= GAIN_UNITY;
            r_again2   <= GAIN_UNITY;
            r_cgain1   <= GAIN_UNITY;
            r_cgain2   <= GAIN_UNITY;
            r_strength <= GAIN_HALF;
            r_base     <= GAIN_UNITY;
            r_aroute   <= AROUTE_RESET;
            r_croute   <= CROUTE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AUDIO_GAIN_ONE:   r_again1   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_AUDIO_GAIN_TWO:   r_again2   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CONTROL_GAIN_ONE: r_cgain1   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CONTROL_GAIN_TWO: r_cgain2   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CONTROL_STRENGTH: r_strength <= i_cfg_data[GAIN_BITS-1:0];
                CFG_BASE_LEVEL:       r_base     <= i_cfg_data[GAIN_BITS-1:0];
                CFG_AUDIO_ROUTING:    r_aroute   <= i_cfg_data[AROUTE_BITS-1:0];
                CFG_CONTROL_ROUTING:  r_croute   <= i_cfg_data[CROUTE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        stg_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign vld_in = {r_vld, i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    // routing decode
    always_comb begin
        use_c1   = (r_croute == CROUTE_ONE) || (r_croute == CROUTE_SUM);
        use_c2   = (r_croute == CROUTE_TWO) || (r_croute == CROUTE_SUM);
        use_mul  = (r_croute == CROUTE_MUL);
        ctl_none = !(use_c1 || use_c2 || use_mul);
    end

    // stage 1: gains times samples
    always_comb begin
        n_s1_pc1 = $signed({1'b0, r_cgain1}) * i_control_one;
        n_s1_pc2 = $signed({1'b0, r_cgain2}) * i_control_two;
        n_s1_pa1 = $signed({1'b0, r_again1}) * i_audio_one;
        n_s1_pa2 = $signed({1'b0, r_again2}) * i_audio_two;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_pc1 <= n_s1_pc1;
            r_s1_pc2 <= n_s1_pc2;
            r_s1_pa1 <= n_s1_pa1;
            r_s1_pa2 <= n_s1_pa2;
            r_s1_end <= i_block_end;
        end
    end

    // stage 2: control terms, control product, routed audio sum
    always_comb begin
        c1       = $signed(CTL_W'(r_s1_pc1 >>> (SAMPLE_BITS - 1)));
        c2       = $signed(CTL_W'(r_s1_pc2 >>> (SAMPLE_BITS - 1)));
        term1    = use_c1 ? CSUM_W'(c1) : '0;
        term2    = use_c2 ? CSUM_W'(c2) : '0;
        n_s2_vsum = term1 + term2;
        c1_pos   = !c1[CTL_W-1] && (c1 != '0);
        c2_pos   = !c2[CTL_W-1] && (c2 != '0);
        n_s2_cmul = (c1_pos && c2_pos) ?
                    CMUL_W'(c1[GAIN_BITS-1:0]) * CMUL_W'(c2[GAIN_BITS-1:0]) : '0;
        au_sum = (r_aroute[1] ? AU_SUM_W'(r_s1_pa1) : '0)
               + (r_aroute[0] ? AU_SUM_W'(r_s1_pa2) : '0);
        au_sh  = au_sum >>> GAIN_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_vsum <= n_s2_vsum;
            r_s2_cmul <= n_s2_cmul;
            r_s2_mul  <= use_mul;
            r_s2_au   <= $signed(au_sh[AU_W-1:0]);
            r_s2_end  <= r_s1_end;
        end
    end

    // stage 3: clip at zero and apply strength
    always_comb begin
        if (r_s2_mul) begin
            v_sel = V_W'(r_s2_cmul[CMUL_W-1:GAIN_FRAC_BITS]);
        end else if (r_s2_vsum[CSUM_W-1]) begin
            v_sel = '0;
        end else begin
            v_sel = V_W'(r_s2_vsum[GAIN_BITS:0]);
        end
        n_s3_vs = VS_W'(v_sel) * VS_W'(r_strength);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_vs  <= n_s3_vs;
            r_s3_au  <= r_s2_au;
            r_s3_end <= r_s2_end;
        end
    end

    // stage 4: add base level, clamp to unity; base level alone, unclamped, when no control is routed
    always_comb begin
        lvl = LVL_W'(r_s3_vs >> GAIN_FRAC_BITS) + LVL_W'(r_base);
        if (ctl_none) begin
            n_s4_gain = r_base;
        end else if (lvl > LVL_UNITY) begin
            n_s4_gain = GAIN_UNITY;
        end else begin
            n_s4_gain = lvl[GAIN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_gain <= n_s4_gain;
            r_s4_au   <= r_s3_au;
            r_s4_end  <= r_s3_end;
        end
    end

    // stage 5: audio times control gain
    assign n_s5_y = r_s4_au * $signed({1'b0, r_s4_gain});

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s5_y   <= n_s5_y;
            r_s5_end <= r_s4_end;
        end
    end

    // stage 6: rescale and saturate
    always_comb begin
        y_sh = r_s5_y >>> GAIN_FRAC_BITS;
        if (y_sh > SAT_MAX) begin
            n_s6_out = $signed(SAT_MAX[SAMPLE_BITS-1:0]);
        end else if (y_sh < SAT_MIN) begin
            n_s6_out = $signed(SAT_MIN[SAMPLE_BITS-1:0]);
        end else begin
            n_s6_out = $signed(y_sh[SAMPLE_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s6_out <= n_s6_out;
            r_s6_end <= r_s5_end;
        end
    end

    // ports
    assign o_in_ready      = stg_en[0];
    assign o_out_valid     = r_vld[STAGES-1];
    assign o_amp_sample    = r_s6_out;
    assign o_block_end_out = r_s6_end;

endmodule

// ===== tb/sv/controlled_audio_amplifier_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// controlled_audio_amplifier_checker
// Follows register writes and frame requests into the amplifier, works out
// each amplified sample and compares it with the output channel in order.
// ---------------------------------------------------------------------------
module controlled_audio_amplifier_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cap_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [cap_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0] i_audio_one,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0] i_audio_two,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0] i_control_one,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0] i_control_two,
    input  logic                                   i_block_end,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [cap_pkg::SAMPLE_BITS-1:0] i_amp_sample,
    input  logic                                   i_block_end_out,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import cap_pkg::*;

    localparam longint UNITY         = longint'(1) << GAIN_FRAC_BITS;
    localparam longint SAMPLE_TOP    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } t_amp_result;

    // own copy of the register file
    logic [GAIN_BITS-1:0]   aud_gain_one;
    logic [GAIN_BITS-1:0]   aud_gain_two;
    logic [GAIN_BITS-1:0]   ctl_gain_one;
    logic [GAIN_BITS-1:0]   ctl_gain_two;
    logic [GAIN_BITS-1:0]   ctl_strength;
    logic [GAIN_BITS-1:0]   ctl_base;
    logic [AROUTE_BITS-1:0] aud_route;
    logic [CROUTE_BITS-1:0] ctl_route;

    t_amp_result expected_samples[$];
    t_amp_result want;
    int          fail_count;

    assign o_fail_count = fail_count;

    // gain applied to the audio mix, in the unsigned gain format
    function automatic longint control_level(input logic signed [SAMPLE_BITS-1:0] x1,
                                             input logic signed [SAMPLE_BITS-1:0] x2);
        longint c1;
        longint c2;
        longint v;
        c1 = (longint'(ctl_gain_one) * longint'(x1)) >>> (SAMPLE_BITS - 1);
        c2 = (longint'(ctl_gain_two) * longint'(x2)) >>> (SAMPLE_BITS - 1);
        case (ctl_route)
            CROUTE_TWO: v = c2;
            CROUTE_ONE: v = c1;
            CROUTE_SUM: v = c1 + c2;
            CROUTE_MUL: v = (c1 > 0 && c2 > 0) ? (c1 * c2) >>> GAIN_FRAC_BITS : 0;
            // no control routed, spare codes too: base level alone, unclamped
            default: return longint'(ctl_base);
        endcase
        if (v < 0) begin
            v = 0;
        end else begin
            v = (v * longint'(ctl_strength)) >>> GAIN_FRAC_BITS;
        end
        v += longint'(ctl_base);
        if (v > UNITY) begin
            v = UNITY;
        end
        return v;
    endfunction

    // output sample for one frame
    function automatic t_amp_result amplified_sample(
        input logic signed [SAMPLE_BITS-1:0] a1,
        input logic signed [SAMPLE_BITS-1:0] a2,
        input logic signed [SAMPLE_BITS-1:0] x1,
        input logic signed [SAMPLE_BITS-1:0] x2,
        input logic                          be
    );
        longint      mix;
        longint      y;
        t_amp_result r;
        if (aud_route == AROUTE_NONE) begin
            y = 0;
        end else begin
            case (aud_route)
                AROUTE_TWO: mix = longint'(aud_gain_two) * longint'(a2);
                AROUTE_ONE: mix = longint'(aud_gain_one) * longint'(a1);
                default:    mix = longint'(aud_gain_one) * longint'(a1)
                                + longint'(aud_gain_two) * longint'(a2);
            endcase
            mix = mix >>> GAIN_FRAC_BITS;
            y = (mix * control_level(x1, x2)) >>> GAIN_FRAC_BITS;
            if (y > SAMPLE_TOP) begin
                y = SAMPLE_TOP;
            end
            if (y < SAMPLE_BOTTOM) begin
                y = SAMPLE_BOTTOM;
            end
        end
        r.sample    = y[SAMPLE_BITS-1:0];
        r.block_end = be;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        fail_count++;
    endtask

    // register writes, frame requests and output requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            aud_gain_one <= GAIN_UNITY;
            aud_gain_two <= GAIN_UNITY;
            ctl_gain_one <= GAIN_UNITY;
            ctl_gain_two <= GAIN_UNITY;
            ctl_strength <= GAIN_HALF;
            ctl_base     <= GAIN_UNITY;
            aud_route    <= AROUTE_RESET;
            ctl_route    <= CROUTE_RESET;
            expected_samples.delete();
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AUDIO_GAIN_ONE:   aud_gain_one <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_AUDIO_GAIN_TWO:   aud_gain_two <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_CONTROL_GAIN_ONE: ctl_gain_one <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_CONTROL_GAIN_TWO: ctl_gain_two <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_CONTROL_STRENGTH: ctl_strength <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_BASE_LEVEL:       ctl_base     <= i_cfg_data[GAIN_BITS-1:0];
                    CFG_AUDIO_ROUTING:    aud_route    <= i_cfg_data[AROUTE_BITS-1:0];
                    CFG_CONTROL_ROUTING:  ctl_route    <= i_cfg_data[CROUTE_BITS-1:0];
                    default: ;
                endcase
            end
            // compare against the oldest outstanding frame
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("output request with no frame outstanding");
                end else begin
                    want = expected_samples.pop_front();
                    if (i_amp_sample !== want.sample) begin
                        report_mismatch($sformatf("amp sample %0d, expected %0d",
                                                  i_amp_sample, want.sample));
                    end
                    if (i_block_end_out !== want.block_end) begin
                        report_mismatch($sformatf("block_end_out %b, expected %b",
                                                  i_block_end_out, want.block_end));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(amplified_sample(i_audio_one, i_audio_two,
                                                            i_control_one, i_control_two,
                                                            i_block_end));
            end
            o_pending <= expected_samples.size();
        end
    end

endmodule

// ===== tb/sv/controlled_audio_amplifier_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// controlled_audio_amplifier_test
// Drives frames and register settings into the amplifier with random gaps on
// both channels; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module controlled_audio_amplifier_test;
    import cap_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic [GAIN_BITS-1:0]          GAIN_MAX   = 18'h3FFFF;
    // spare control routing codes, handled as no control routing
    localparam logic [CROUTE_BITS-1:0] CROUTE_SPARE_LO  = 3'd5;
    localparam logic [CROUTE_BITS-1:0] CROUTE_SPARE_MID = 3'd6;
    localparam logic [CROUTE_BITS-1:0] CROUTE_SPARE_HI  = 3'd7;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_idx     = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data    = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] audio_one   = '0;
    logic signed [SAMPLE_BITS-1:0] audio_two   = '0;
    logic signed [SAMPLE_BITS-1:0] control_one = '0;
    logic signed [SAMPLE_BITS-1:0] control_two = '0;
    logic                          block_end   = 1'b0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] amp_sample;
    logic                          block_end_out;
    int                            fail_count;
    int                            pending;
    int                            ready_cycles = 0;

    controlled_audio_amplifier dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_audio_one     (audio_one),
        .i_audio_two     (audio_two),
        .i_control_one   (control_one),
        .i_control_two   (control_two),
        .i_block_end     (block_end),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_amp_sample    (amp_sample),
        .o_block_end_out (block_end_out)
    );

    controlled_audio_amplifier_checker result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_audio_one     (audio_one),
        .i_audio_two     (audio_two),
        .i_control_one   (control_one),
        .i_control_two   (control_two),
        .i_block_end     (block_end),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_amp_sample    (amp_sample),
        .i_block_end_out (block_end_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // output stalls, with a stretch of steady acceptance
    always @(posedge clk) begin
        ready_cycles <= ready_cycles + 1;
        out_ready    <= (ready_cycles >= 350 && ready_cycles < 550)
                        || ($urandom_range(99) >= 16);
    end

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_UNITY;
            default: return GAIN_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // mostly a routed input, now and then none
    function automatic logic [AROUTE_BITS-1:0] pick_audio_route();
        if ($urandom_range(0, 7) == 0) begin
            return AROUTE_NONE;
        end
        return AROUTE_BITS'($urandom_range(AROUTE_TWO, AROUTE_SUM));
    endfunction

    // mostly a real control path, sometimes any code incl. the spare ones
    function automatic logic [CROUTE_BITS-1:0] pick_control_route();
        if ($urandom_range(0, 3) == 0) begin
            return CROUTE_BITS'($urandom_range(0, 7));
        end
        return CROUTE_BITS'($urandom_range(CROUTE_TWO, CROUTE_MUL));
    endfunction

    // drop valid and wait for every frame to come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] gain_one,
                            input logic [CFG_DATA_BITS-1:0] gain_two,
                            input logic [CFG_DATA_BITS-1:0] ctl_one,
                            input logic [CFG_DATA_BITS-1:0] ctl_two,
                            input logic [CFG_DATA_BITS-1:0] strength,
                            input logic [CFG_DATA_BITS-1:0] base,
                            input logic [CFG_DATA_BITS-1:0] aroute,
                            input logic [CFG_DATA_BITS-1:0] croute);
        wait_idle();
        write_reg(CFG_AUDIO_GAIN_ONE, gain_one);
        write_reg(CFG_AUDIO_GAIN_TWO, gain_two);
        write_reg(CFG_CONTROL_GAIN_ONE, ctl_one);
        write_reg(CFG_CONTROL_GAIN_TWO, ctl_two);
        write_reg(CFG_CONTROL_STRENGTH, strength);
        write_reg(CFG_BASE_LEVEL, base);
        write_reg(CFG_AUDIO_ROUTING, aroute);
        write_reg(CFG_CONTROL_ROUTING, croute);
        cfg_we <= 1'b0;
    endtask

    // hold one frame request until it is taken
    task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] a1,
                              input logic signed [SAMPLE_BITS-1:0] a2,
                              input logic signed [SAMPLE_BITS-1:0] x1,
                              input logic signed [SAMPLE_BITS-1:0] x2,
                              input logic                          be);
        in_valid    <= 1'b1;
        audio_one   <= a1;
        audio_two   <= a2;
        control_one <= x1;
        control_two <= x2;
        block_end   <= be;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin
        int item;
        item = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: both inputs summed, gain is the base level
        send_frame(SAMPLE_MAX, SAMPLE_MAX, '0, '0, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, '0, '0, 1'b0);
        send_frame('0, -24'sd1, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0);

        // everything at full scale, input one, summed control, no base
        set_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, '0,
                 CFG_DATA_BITS'(AROUTE_ONE), CFG_DATA_BITS'(CROUTE_SUM));
        send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_frame(24'sd12345, '0, 24'sd1, -24'sd1, 1'b1);

        // multiplied control on input two: both positive, mixed, both negative
        set_regs(GAIN_UNITY, GAIN_HALF, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, '0,
                 CFG_DATA_BITS'(AROUTE_TWO), CFG_DATA_BITS'(CROUTE_MUL));
        send_frame(SAMPLE_MAX, 24'sd4000000, 24'sd4194304, 24'sd4194304, 1'b0);
        send_frame(SAMPLE_MAX, 24'sd4000000, SAMPLE_MAX, -24'sd4194304, 1'b1);
        send_frame('0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);

        // no audio routed gives silence
        set_regs(GAIN_UNITY, GAIN_UNITY, GAIN_MAX, '0, GAIN_HALF, GAIN_HALF,
                 CFG_DATA_BITS'(AROUTE_NONE), CFG_DATA_BITS'(CROUTE_ONE));
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);

        // large base level with control routed is clamped to unity
        set_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_MAX, GAIN_HALF, GAIN_MAX,
                 CFG_DATA_BITS'(AROUTE_SUM), CFG_DATA_BITS'(CROUTE_TWO));
        send_frame(SAMPLE_MAX, '0, '0, SAMPLE_MAX, 1'b1);
        send_frame(-24'sd3000000, -24'sd3000000, '0, SAMPLE_MIN, 1'b0);

        // spare routing code: base level above unity is kept as is
        set_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_HALF, GAIN_MAX,
                 CFG_DATA_BITS'(AROUTE_SUM), CFG_DATA_BITS'(CROUTE_SPARE_LO));
        send_frame(24'sd4194304, '0, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(-24'sd1000000, -24'sd1000000, '0, '0, 1'b0);

        // upper data bits of routing writes are ignored
        set_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_HALF, GAIN_HALF,
                 {16'hFFFF, AROUTE_ONE}, {15'h7FFF, CROUTE_SPARE_MID});
        send_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        set_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_HALF, '0,
                 CFG_DATA_BITS'(AROUTE_SUM), CFG_DATA_BITS'(CROUTE_SPARE_HI));
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);

        // random settings, each followed by a run of random frames
        for (int phase = 0; phase < 6; phase++) begin
            set_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                     pick_gain(), {16'($urandom), pick_audio_route()},
                     {15'($urandom), pick_control_route()});
            for (int n = 0; n < 85; n++) begin
                if (!(item >= 200 && item < 300) && $urandom_range(99) < 16) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
                send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                           1'($urandom));
                item++;
            end
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== controlled_audio_amplifier.f =====
rtl/cap_pkg.sv
rtl/controlled_audio_amplifier.sv
tb/sv/controlled_audio_amplifier_checker.sv
tb/sv/controlled_audio_amplifier_test.sv
